// File: sv/saf_pkg.sv
`timescale 1ns / 1ps

package saf_pkg;

    // Field widths of the configuration registers and the result.
    localparam int THR_W    = 12;
    localparam int DUTY_W   = 7;
    localparam int DEV_MG_W = 12;
    localparam int EVENT_W  = 2;
    localparam int STATUS_W = 3;
    localparam int REG_IDX_W = 3;

    // Scaling and limits.
    localparam int MG_PER_G = 1000;
    localparam logic [DUTY_W-1:0]   DUTY_MAX = 7'd100;
    localparam logic [DEV_MG_W-1:0] DEV_MAX  = 12'd4095;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SHAKE_THR  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAS_THR    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_QUIET_DUTY = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHAKE_DUTY = 3'd3;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]  RST_SHAKE_THR  = 12'd300;
    localparam logic [THR_W-1:0]  RST_GAS_THR    = 12'd1500;
    localparam logic [DUTY_W-1:0] RST_QUIET_DUTY = 7'd5;
    localparam logic [DUTY_W-1:0] RST_SHAKE_DUTY = 7'd90;

    // Shake event codes.
    localparam logic [EVENT_W-1:0] EVT_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EVT_DETECT = 2'd1;
    localparam logic [EVENT_W-1:0] EVT_CLEAR  = 2'd2;

    // Alert status codes.
    localparam logic [STATUS_W-1:0] STAT_NONE      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FLAME_GAS = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FLAME     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_GAS       = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SAFE      = 3'd4;

    typedef struct packed {
        logic [THR_W-1:0]  shake_thr;
        logic [THR_W-1:0]  gas_thr;
        logic [DUTY_W-1:0] quiet_duty;
        logic [DUTY_W-1:0] shake_duty;
    } cfg_t;

    typedef struct packed {
        logic [DEV_MG_W-1:0] deviation_mg;
        logic [DUTY_W-1:0]   led_duty;
        logic                shaking;
        logic [EVENT_W-1:0]  shake_event;
        logic [STATUS_W-1:0] status_code;
        logic                buzzer;
        logic                flame_led_on;
    } result_t;

endpackage

// File: sv/saf_queue.sv
`timescale 1ns / 1ps

module saf_queue #(
    parameter int WIDTH = 51
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] dout
);

    // Two-entry circular buffer between the front and back ends.
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign dout      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Storage; no reset needed for the payload.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: sv/saf_front.sv
`timescale 1ns / 1ps

module saf_front #(
    parameter int ACCEL_BITS = 16,
    parameter int GAS_BITS   = 12
) (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          accel_valid,
    input  logic signed [ACCEL_BITS-1:0]  accel_x,
    input  logic signed [ACCEL_BITS-1:0]  accel_y,
    input  logic signed [ACCEL_BITS-1:0]  accel_z,
    input  logic                          flame_seen,
    input  logic [GAS_BITS-1:0]           gas_level,
    input  logic [saf_pkg::THR_W-1:0]     gas_thr,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [3*ACCEL_BITS+2:0]       q_data
);
    import saf_pkg::*;

    localparam int GCMP_W = (GAS_BITS > THR_W) ? GAS_BITS : THR_W;

    logic [ACCEL_BITS-1:0] mag_x;
    logic [ACCEL_BITS-1:0] mag_y;
    logic [ACCEL_BITS-1:0] mag_z;
    logic                  gas_hi;

    // Take items whenever the queue has room.
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Axis magnitudes; the most negative code maps to its unsigned magnitude.
    assign mag_x = accel_x[ACCEL_BITS-1] ? (~accel_x + 1'b1) : accel_x;
    assign mag_y = accel_y[ACCEL_BITS-1] ? (~accel_y + 1'b1) : accel_y;
    assign mag_z = accel_z[ACCEL_BITS-1] ? (~accel_z + 1'b1) : accel_z;

    // Gas alarm classification against the threshold.
    assign gas_hi = GCMP_W'(gas_level) > GCMP_W'(gas_thr);

    // Classified item toward the back end.
    assign q_data = {accel_valid, flame_seen, gas_hi, mag_x, mag_y, mag_z};

endmodule

// File: sv/saf_back.sv
`timescale 1ns / 1ps

module saf_back #(
    parameter int ACCEL_BITS   = 16,
    parameter int ONE_G_COUNTS = 16384
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  saf_pkg::cfg_t            cfg,
    input  logic                     q_valid,
    input  logic [3*ACCEL_BITS+2:0]  q_data,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output saf_pkg::result_t         result
);
    import saf_pkg::*;

    localparam int AB      = ACCEL_BITS;
    localparam int SUM_W   = 2 * AB;
    localparam int REM_W   = AB + 2;
    localparam int DEV_W   = (AB > 15) ? AB : 15;
    localparam int PROD_W  = DEV_W + 12;
    localparam int CNT_W   = ($clog2(AB) > 4) ? $clog2(AB) : 4;
    // Reciprocal of one g, exact for every product below 2^PROD_W.
    localparam int RCP_SH  = PROD_W + $clog2(ONE_G_COUNTS);
    localparam int RCP_W   = PROD_W + 1;
    localparam int SCL_W   = PROD_W + RCP_W;
    localparam logic [DEV_W-1:0]  ONE_G_D = DEV_W'(ONE_G_COUNTS);
    localparam logic [PROD_W-1:0] ONE_G_P = PROD_W'(ONE_G_COUNTS);
    localparam logic [PROD_W-1:0] DIV_TOP = ONE_G_P << DEV_MG_W;
    localparam logic [PROD_W-1:0] MG_P    = PROD_W'(MG_PER_G);
    localparam logic [RCP_W-1:0]  RECIP   = RCP_W'(((64'd1 << RCP_SH)
                                            + 64'(ONE_G_COUNTS) - 64'd1)
                                            / 64'(ONE_G_COUNTS));
    localparam logic [CNT_W-1:0]  ROOT_LAST = CNT_W'(AB - 1);
    localparam logic [CNT_W-1:0]  SQR_LAST  = CNT_W'(3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_ROOT,
        S_DEV,
        S_MUL,
        S_SAT,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                valid_reg, valid_next;
    logic                flame_reg, flame_next;
    logic                gas_hi_reg, gas_hi_next;
    logic [AB-1:0]       mx_reg, mx_next;
    logic [AB-1:0]       my_reg, my_next;
    logic [AB-1:0]       mz_reg, mz_next;
    logic [SUM_W-1:0]    sq_reg, sq_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [AB-1:0]       root_reg, root_next;
    logic [DEV_W-1:0]    dev_reg, dev_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [DEV_MG_W-1:0] quo_reg, quo_next;
    logic                flag_reg, flag_next;
    logic                out_valid_reg, out_valid_next;
    result_t             result_reg, result_next;

    logic                e_valid;
    logic                e_flame;
    logic                e_gas_hi;
    logic [AB-1:0]       e_mx;
    logic [AB-1:0]       e_my;
    logic [AB-1:0]       e_mz;

    assign {e_valid, e_flame, e_gas_hi, e_mx, e_my, e_mz} = q_data;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Sequencer: squares, root, deviation, scaling, then the shake decision.
    always_comb
    begin
        logic [AB-1:0]     sq_a;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [SCL_W-1:0]  scaled;
        logic              thr_hit;
        logic              below_half;
        logic [DUTY_W-1:0] duty_sel;
        logic [EVENT_W-1:0] evt;
        logic [STATUS_W-1:0] stat;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        valid_next     = valid_reg;
        flame_next     = flame_reg;
        gas_hi_next    = gas_hi_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mz_next        = mz_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        dev_next       = dev_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        sq_a       = mx_reg;
        rem_sh     = {rem_reg[AB-1:0], sum_reg[SUM_W-1 -: 2]};
        trial      = {root_reg, 2'b01};
        scaled     = {{RCP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RECIP};
        thr_hit    = quo_reg >= cfg.shake_thr;
        below_half = quo_reg < (cfg.shake_thr >> 1);
        duty_sel   = cfg.quiet_duty;
        evt        = EVT_NONE;
        stat       = STAT_NONE;

        // The output register empties when the consumer takes the item.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    valid_next  = e_valid;
                    flame_next  = e_flame;
                    gas_hi_next = e_gas_hi;
                    mx_next     = e_mx;
                    my_next     = e_my;
                    mz_next     = e_mz;
                    sum_next    = '0;
                    quo_next    = '0;
                    cnt_next    = '0;
                    state_next  = e_valid ? S_SQR : S_DONE;
                end
            end

            S_SQR:
            begin
                // One axis squared per cycle, each square summed in the next cycle.
                case (cnt_reg[1:0])
                    2'd0:    sq_a = mx_reg;
                    2'd1:    sq_a = my_reg;
                    default: sq_a = mz_reg;
                endcase
                sq_next = {{AB{1'b0}}, sq_a} * {{AB{1'b0}}, sq_a};
                if (cnt_reg != '0)
                begin
                    sum_next = sum_reg + sq_reg;
                end
                if (cnt_reg == SQR_LAST)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = S_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_ROOT:
            begin
                // Digit-by-digit square root, two radicand bits per step.
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[AB-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[AB-2:0], 1'b0};
                end
                sum_next = sum_reg << 2;
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = S_DEV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DEV:
            begin
                if (DEV_W'(root_reg) >= ONE_G_D)
                begin
                    dev_next = DEV_W'(root_reg) - ONE_G_D;
                end
                else
                begin
                    dev_next = ONE_G_D - DEV_W'(root_reg);
                end
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = PROD_W'(dev_reg) * MG_P;
                state_next = S_SAT;
            end

            S_SAT:
            begin
                // Quotients that would not fit saturate right away.
                if (prod_reg >= DIV_TOP)
                begin
                    quo_next   = DEV_MAX;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // Division by one g as a multiply by its rounded-up reciprocal.
                quo_next   = scaled[RCP_SH +: DEV_MG_W];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hysteresis update and result assembly.
                if (valid_reg)
                begin
                    if (thr_hit)
                    begin
                        duty_sel = cfg.shake_duty;
                    end
                    if (!flag_reg && thr_hit)
                    begin
                        flag_next = 1'b1;
                        evt       = EVT_DETECT;
                    end
                    else if (flag_reg && below_half)
                    begin
                        flag_next = 1'b0;
                        evt       = EVT_CLEAR;
                    end
                end
                else if (flag_reg)
                begin
                    flag_next = 1'b0;
                    evt       = EVT_CLEAR;
                end

                if (flame_reg && gas_hi_reg)
                begin
                    stat = STAT_FLAME_GAS;
                end
                else if (flame_reg)
                begin
                    stat = STAT_FLAME;
                end
                else if (gas_hi_reg)
                begin
                    stat = STAT_GAS;
                end
                else if (!flag_next)
                begin
                    stat = STAT_SAFE;
                end

                if (!out_valid_reg || out_ready)
                begin
                    result_next.deviation_mg = quo_reg;
                    result_next.led_duty     = (duty_sel > DUTY_MAX) ? DUTY_MAX : duty_sel;
                    result_next.shaking      = flag_next;
                    result_next.shake_event  = evt;
                    result_next.status_code  = stat;
                    result_next.buzzer       = gas_hi_reg;
                    result_next.flame_led_on = flame_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
                else
                begin
                    flag_next = flag_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= 1'b0;
            flame_reg     <= 1'b0;
            gas_hi_reg    <= 1'b0;
            mx_reg        <= '0;
            my_reg        <= '0;
            mz_reg        <= '0;
            sq_reg        <= '0;
            sum_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            dev_reg       <= '0;
            prod_reg      <= '0;
            quo_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            flame_reg     <= flame_next;
            gas_hi_reg    <= gas_hi_next;
            mx_reg        <= mx_next;
            my_reg        <= my_next;
            mz_reg        <= mz_next;
            sq_reg        <= sq_next;
            sum_reg       <= sum_next;
            rem_reg       <= rem_next;
            root_reg      <= root_next;
            dev_reg       <= dev_next;
            prod_reg      <= prod_next;
            quo_reg       <= quo_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    // A detection event always leaves the block shaking.
    a_detect_sets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.shake_event == EVT_DETECT |-> result_reg.shaking)
        else $error("detect event without shaking");

    // A clear event always leaves the block quiet.
    a_clear_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.shake_event == EVT_CLEAR |-> !result_reg.shaking)
        else $error("clear event while shaking");

    // The safe status is never reported while shaking.
    a_safe_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.shaking |-> result_reg.status_code != STAT_SAFE)
        else $error("safe status while shaking");

    // A new result only appears on leaving the final state.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside final state");

    // The flag only moves when a result is loaded.
    a_flag_moves: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg != $past(flag_reg) |-> $past(state_reg == S_DONE))
        else $error("shake flag changed outside final state");

endmodule

// File: sv/shake_gas_flame_alarm_unit.sv
`timescale 1ns / 1ps

// Shake, gas and flame alarm. Each sample item enters through a two-entry queue,
// so up to two items are taken while the back end is busy or its result waits.
// A valid sample passes through the back end in steps: one shared multiplier
// squares the three axes in turn, the square root unit resolves one result bit
// per cycle, then come one deviation step, one multiply by 1000, one range check
// and one multiply by the reciprocal of one g, plus one step to load the result
// and one to fetch the next item. A deviation that saturates skips the last
// multiply. An invalid sample goes straight to loading its result. The shake
// flag sets when the deviation reaches the shake threshold and clears below half
// of it or on an invalid sample. Configuration writes take effect at once and are
// meant to be made while no item is in flight; indexes 0 to 3 select, in order,
// the shake threshold, gas threshold, quiet duty and shake duty, and other
// indexes are ignored.
module shake_gas_flame_alarm_unit #(
    parameter int ACCEL_BITS   = 16,
    parameter int ONE_G_COUNTS = 16384,
    parameter int GAS_BITS     = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [saf_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [saf_pkg::THR_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              accel_valid,
    input  logic signed [ACCEL_BITS-1:0]      accel_x,
    input  logic signed [ACCEL_BITS-1:0]      accel_y,
    input  logic signed [ACCEL_BITS-1:0]      accel_z,
    input  logic                              flame_seen,
    input  logic [GAS_BITS-1:0]               gas_level,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [saf_pkg::DEV_MG_W-1:0]      deviation_mg,
    output logic [saf_pkg::DUTY_W-1:0]        led_duty,
    output logic                              shaking,
    output logic [saf_pkg::EVENT_W-1:0]       shake_event,
    output logic [saf_pkg::STATUS_W-1:0]      status_code,
    output logic                              buzzer,
    output logic                              flame_led_on
);
    import saf_pkg::*;

    localparam int ENTRY_W = 3 * ACCEL_BITS + 3;

    cfg_t               cfg_reg;
    logic               q_full;
    logic               q_push;
    logic [ENTRY_W-1:0] q_din;
    logic               q_pop;
    logic               q_not_empty;
    logic [ENTRY_W-1:0] q_dout;
    result_t            result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shake_thr  <= RST_SHAKE_THR;
            cfg_reg.gas_thr    <= RST_GAS_THR;
            cfg_reg.quiet_duty <= RST_QUIET_DUTY;
            cfg_reg.shake_duty <= RST_SHAKE_DUTY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHAKE_THR:  cfg_reg.shake_thr  <= cfg_data;
                REG_GAS_THR:    cfg_reg.gas_thr    <= cfg_data;
                REG_QUIET_DUTY: cfg_reg.quiet_duty <= cfg_data[DUTY_W-1:0];
                REG_SHAKE_DUTY: cfg_reg.shake_duty <= cfg_data[DUTY_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end: accepts and classifies items.
    saf_front #(
        .ACCEL_BITS (ACCEL_BITS),
        .GAS_BITS   (GAS_BITS)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .accel_valid (accel_valid),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .flame_seen  (flame_seen),
        .gas_level   (gas_level),
        .gas_thr     (cfg_reg.gas_thr),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_din)
    );

    // Queue between the two ends.
    saf_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_din),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .dout      (q_dout)
    );

    // Back end: magnitude, deviation and alarm decision.
    saf_back #(
        .ACCEL_BITS   (ACCEL_BITS),
        .ONE_G_COUNTS (ONE_G_COUNTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_data    (q_dout),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign deviation_mg = result.deviation_mg;
    assign led_duty     = result.led_duty;
    assign shaking      = result.shaking;
    assign shake_event  = result.shake_event;
    assign status_code  = result.status_code;
    assign buzzer       = result.buzzer;
    assign flame_led_on = result.flame_led_on;

endmodule

// File: sim/shake_gas_flame_alarm_checker.sv
`timescale 1ns / 1ps

module shake_gas_flame_alarm_checker #(
    parameter int ACCEL_BITS   = 16,
    parameter int ONE_G_COUNTS = 16384,
    parameter int GAS_BITS     = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [saf_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [saf_pkg::THR_W-1:0]         cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              accel_valid,
    input  logic signed [ACCEL_BITS-1:0]      accel_x,
    input  logic signed [ACCEL_BITS-1:0]      accel_y,
    input  logic signed [ACCEL_BITS-1:0]      accel_z,
    input  logic                              flame_seen,
    input  logic [GAS_BITS-1:0]               gas_level,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [saf_pkg::DEV_MG_W-1:0]      deviation_mg,
    input  logic [saf_pkg::DUTY_W-1:0]        led_duty,
    input  logic                              shaking,
    input  logic [saf_pkg::EVENT_W-1:0]       shake_event,
    input  logic [saf_pkg::STATUS_W-1:0]      status_code,
    input  logic                              buzzer,
    input  logic                              flame_led_on,
    output int                                mismatches,
    output int                                outstanding,
    output int                                samples_seen,
    output int                                reports_seen,
    output int                                detections,
    output int                                clearances
);

    import saf_pkg::*;

    localparam longint unsigned ONE_G = ONE_G_COUNTS;

    // One sensor sample item as it crossed the input channel.
    typedef struct packed {
        logic                         accel_valid;
        logic signed [ACCEL_BITS-1:0] ax;
        logic signed [ACCEL_BITS-1:0] ay;
        logic signed [ACCEL_BITS-1:0] az;
        logic                         flame;
        logic [GAS_BITS-1:0]          gas;
    } sensor_sample_t;

    // Local copy of the register file and of the shake state.
    logic [THR_W-1:0]  shake_thr;
    logic [THR_W-1:0]  gas_thr;
    logic [DUTY_W-1:0] quiet_duty;
    logic [DUTY_W-1:0] shake_duty;
    logic              shake_flag;

    // Alarm reports predicted for samples that have not come out yet.
    result_t awaited_reports[$];

    // Largest r with r * r <= n, found one bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= n)
                r = trial;
        end
        return r;
    endfunction

    function automatic longint unsigned axis_power(input logic signed [ACCEL_BITS-1:0] a);
        longint v;
        v = longint'(a);
        if (v < 0)
            v = -v;
        return longint'(v * v);
    endfunction

    // Alarm report for one sample, given the shake state before it.
    function automatic result_t alarm_outcome(input sensor_sample_t s, input logic flag);
        result_t           r;
        longint unsigned   total;
        longint unsigned   mag;
        longint unsigned   dev;
        longint unsigned   mg;
        logic [DEV_MG_W-1:0] dev_mg;
        logic [DUTY_W-1:0] duty;
        logic              gas_hi;
        logic              next_flag;

        dev_mg = '0;
        duty = quiet_duty;
        next_flag = flag;
        r.shake_event = EVT_NONE;
        gas_hi = (s.gas > gas_thr);

        if (s.accel_valid)
        begin
            total = axis_power(s.ax) + axis_power(s.ay) + axis_power(s.az);
            mag = floor_root(total);
            dev = (mag >= ONE_G) ? (mag - ONE_G) : (ONE_G - mag);
            mg = (dev * MG_PER_G) / ONE_G;
            dev_mg = (mg > DEV_MAX) ? DEV_MAX : mg[DEV_MG_W-1:0];

            // Duty follows this sample's deviation, not the flag.
            if (dev_mg >= shake_thr)
                duty = shake_duty;

            // Hysteresis: set at the threshold, clear below half of it.
            if (!flag && dev_mg >= shake_thr)
            begin
                next_flag = 1'b1;
                r.shake_event = EVT_DETECT;
            end
            else if (flag && dev_mg < (shake_thr >> 1))
            begin
                next_flag = 1'b0;
                r.shake_event = EVT_CLEAR;
            end
        end
        else if (flag)
        begin
            // A failed read drops the shake state.
            next_flag = 1'b0;
            r.shake_event = EVT_CLEAR;
        end

        if (s.flame && gas_hi)
            r.status_code = STAT_FLAME_GAS;
        else if (s.flame)
            r.status_code = STAT_FLAME;
        else if (gas_hi)
            r.status_code = STAT_GAS;
        else if (!next_flag)
            r.status_code = STAT_SAFE;
        else
            r.status_code = STAT_NONE;

        r.deviation_mg = dev_mg;
        r.led_duty = (duty > DUTY_MAX) ? DUTY_MAX : duty;
        r.shaking = next_flag;
        r.buzzer = gas_hi;
        r.flame_led_on = s.flame;
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
        end
    endtask

    // Watch the three ports; results are checked before a new sample is predicted.
    always @(posedge clk or negedge rst_n)
    begin : watch
        sensor_sample_t s;
        result_t        want;

        if (!rst_n)
        begin
            shake_thr <= RST_SHAKE_THR;
            gas_thr <= RST_GAS_THR;
            quiet_duty <= RST_QUIET_DUTY;
            shake_duty <= RST_SHAKE_DUTY;
            shake_flag = 1'b0;
            awaited_reports.delete();
            outstanding <= 0;
            mismatches = 0;
            samples_seen = 0;
            reports_seen = 0;
            detections = 0;
            clearances = 0;
        end
        else
        begin
            // Compare an accepted result with the oldest prediction.
            if (out_valid && out_ready)
            begin
                reports_seen++;
                if (awaited_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result arrived with no sample waiting", $time);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("deviation_mg", 32'(want.deviation_mg), 32'(deviation_mg));
                    check_field("led_duty", 32'(want.led_duty), 32'(led_duty));
                    check_field("shaking", 32'(want.shaking), 32'(shaking));
                    check_field("shake_event", 32'(want.shake_event), 32'(shake_event));
                    check_field("status_code", 32'(want.status_code), 32'(status_code));
                    check_field("buzzer", 32'(want.buzzer), 32'(buzzer));
                    check_field("flame_led_on", 32'(want.flame_led_on), 32'(flame_led_on));
                end
            end

            // Mirror register writes, masked to each register's width.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SHAKE_THR:  shake_thr <= cfg_data;
                    REG_GAS_THR:    gas_thr <= cfg_data;
                    REG_QUIET_DUTY: quiet_duty <= cfg_data[DUTY_W-1:0];
                    REG_SHAKE_DUTY: shake_duty <= cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end

            // Predict the report of an accepted sample item.
            if (in_valid && in_ready)
            begin
                s.accel_valid = accel_valid;
                s.ax = accel_x;
                s.ay = accel_y;
                s.az = accel_z;
                s.flame = flame_seen;
                s.gas = gas_level;
                want = alarm_outcome(s, shake_flag);
                shake_flag = want.shaking;
                awaited_reports.push_back(want);
                samples_seen++;
                if (want.shake_event == EVT_DETECT)
                    detections++;
                if (want.shake_event == EVT_CLEAR)
                    clearances++;
            end

            outstanding <= awaited_reports.size();
        end
    end

endmodule

// File: sim/shake_gas_flame_alarm_unit_test.sv
`timescale 1ns / 1ps

module shake_gas_flame_alarm_unit_test;

    import saf_pkg::*;

    localparam int AXIS_W      = 16;
    localparam int ONE_G       = 16384;
    localparam int GAS_W       = 12;
    localparam int PHASE_ITEMS = 240;
    localparam int STALL_LIMIT = 3000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [REG_IDX_W-1:0]    cfg_index;
    logic [THR_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    accel_valid;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic                    flame_seen;
    logic [GAS_W-1:0]        gas_level;
    logic                    out_valid;
    logic                    out_ready;
    logic [DEV_MG_W-1:0]     deviation_mg;
    logic [DUTY_W-1:0]       led_duty;
    logic                    shaking;
    logic [EVENT_W-1:0]      shake_event;
    logic [STATUS_W-1:0]     status_code;
    logic                    buzzer;
    logic                    flame_led_on;

    int mismatches;
    int outstanding;
    int samples_seen;
    int reports_seen;
    int detections;
    int clearances;

    // Stimulus state: current thresholds steer the random samples.
    bit steady;
    int cur_thr;
    int cur_gas;
    int settings_used;
    int idle_cycles;

    shake_gas_flame_alarm_unit #(
        .ACCEL_BITS   (AXIS_W),
        .ONE_G_COUNTS (ONE_G),
        .GAS_BITS     (GAS_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_valid  (accel_valid),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .flame_seen   (flame_seen),
        .gas_level    (gas_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .deviation_mg (deviation_mg),
        .led_duty     (led_duty),
        .shaking      (shaking),
        .shake_event  (shake_event),
        .status_code  (status_code),
        .buzzer       (buzzer),
        .flame_led_on (flame_led_on)
    );

    shake_gas_flame_alarm_checker #(
        .ACCEL_BITS   (AXIS_W),
        .ONE_G_COUNTS (ONE_G),
        .GAS_BITS     (GAS_W)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_valid  (accel_valid),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .flame_seen   (flame_seen),
        .gas_level    (gas_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .deviation_mg (deviation_mg),
        .led_duty     (led_duty),
        .shaking      (shaking),
        .shake_event  (shake_event),
        .status_code  (status_code),
        .buzzer       (buzzer),
        .flame_led_on (flame_led_on),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .samples_seen (samples_seen),
        .reports_seen (reports_seen),
        .detections   (detections),
        .clearances   (clearances)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Wait drawn per item by either side; none during steady stretches.
    function automatic int pick_gap();
        return steady ? 0 : int'($urandom_range(0, 17));
    endfunction

    // Offer one sample item and hold it until it is taken.
    task automatic send_sample(input logic v, input int x, input int y, input int z,
                               input logic f, input int g);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_valid <= v;
        accel_x <= x[AXIS_W-1:0];
        accel_y <= y[AXIS_W-1:0];
        accel_z <= z[AXIS_W-1:0];
        flame_seen <= f;
        gas_level <= g[GAS_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Random sample: mostly near the shake and gas thresholds, some raw noise.
    task automatic random_sample();
        int   kind;
        int   span;
        int   d;
        int   xi;
        int   yi;
        int   zi;
        int   gi;
        int   t;
        logic v;
        logic f;

        kind = $urandom_range(0, 9);
        v = (kind != 0);
        f = 1'($urandom_range(0, 1));
        if (kind <= 2)
        begin
            xi = int'($urandom_range(0, 65535)) - 32768;
            yi = int'($urandom_range(0, 65535)) - 32768;
            zi = int'($urandom_range(0, 65535)) - 32768;
        end
        else
        begin
            span = (cur_thr * ONE_G) / 1000 + 1;
            d = $urandom_range(0, 2 * span + 64);
            zi = $urandom_range(0, 1) ? ONE_G + d : ONE_G - d;
            if (zi > 32767)
                zi = 32767;
            if (zi < -32768)
                zi = -32768;
            xi = int'($urandom_range(0, 400)) - 200;
            yi = int'($urandom_range(0, 400)) - 200;
            // Move the dominant axis around so every axis carries the load.
            case ($urandom_range(0, 2))
                0: begin t = xi; xi = zi; zi = t; end
                1: begin t = yi; yi = zi; zi = t; end
                default: ;
            endcase
        end
        if ($urandom_range(0, 1))
            gi = $urandom_range(0, 4095);
        else
        begin
            gi = cur_gas + int'($urandom_range(0, 6)) - 3;
            if (gi < 0)
                gi = 0;
            if (gi > 4095)
                gi = 4095;
        end
        send_sample(v, xi, yi, zi, f, gi);
    endtask

    // Let every predicted result come out before touching the registers.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles.
    task automatic load_settings(input int thr, input int gas, input int quiet,
                                 input int shake);
        cfg_we <= 1'b1;
        cfg_index <= REG_SHAKE_THR;
        cfg_data <= thr[THR_W-1:0];
        @(posedge clk);
        cfg_index <= REG_GAS_THR;
        cfg_data <= gas[THR_W-1:0];
        @(posedge clk);
        cfg_index <= REG_QUIET_DUTY;
        cfg_data <= quiet[THR_W-1:0];
        @(posedge clk);
        cfg_index <= REG_SHAKE_DUTY;
        cfg_data <= shake[THR_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_thr = thr & 12'hFFF;
        cur_gas = gas & 12'hFFF;
        settings_used++;
    endtask

    // Result side: stall a drawn number of cycles, then accept one item.
    initial
    begin : result_sink
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Watchdog: too long with no item moving on any port ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL shake_gas_flame_alarm_unit");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int thr;
        int gas;
        int quiet;
        int shake;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_SHAKE_THR;
        cfg_data <= '0;
        in_valid <= 1'b0;
        accel_valid <= 1'b0;
        accel_x <= '0;
        accel_y <= '0;
        accel_z <= '0;
        flame_seen <= 1'b0;
        gas_level <= '0;
        steady = 1'b0;
        cur_thr = int'(RST_SHAKE_THR);
        cur_gas = int'(RST_GAS_THR);
        settings_used = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at the reset settings (threshold 300, clear below 150).
        send_sample(1'b0, 0, 0, 0, 1'b0, 0);             // invalid while idle
        send_sample(1'b1, 0, 0, 16384, 1'b0, 0);         // at rest, safe
        send_sample(1'b1, 0, 0, 21299, 1'b0, 1500);      // 299 mg, gas at threshold
        send_sample(1'b1, 0, 0, 21300, 1'b0, 1501);      // 300 mg sets, gas alarm
        send_sample(1'b1, 0, 0, 13926, 1'b0, 0);         // 150 mg holds, only shaking
        send_sample(1'b1, 0, 0, 13927, 1'b0, 0);         // 149 mg clears
        send_sample(1'b1, 0, 0, -32768, 1'b1, 4095);     // flame and gas while shaking
        send_sample(1'b0, 32767, -32768, 4660, 1'b1, 0); // invalid clears, axes ignored
        send_sample(1'b1, -32768, -32768, -32768, 1'b0, 4095);
        send_sample(1'b1, 32767, 32767, 32767, 1'b1, 0);
        send_sample(1'b1, 0, 0, 0, 1'b0, 0);             // free fall
        send_sample(1'b1, 16384, 0, 0, 1'b0, 0);         // rest on x clears
        send_sample(1'b1, 0, -16384, 0, 1'b1, 1499);
        send_sample(1'b1, 9459, 9459, 9459, 1'b0, 0);
        send_sample(1'b1, 11585, 11585, 0, 1'b0, 2000);
        send_sample(1'b0, -1, -1, -1, 1'b0, 0);          // invalid while idle
        send_sample(1'b1, 0, 0, 32767, 1'b0, 0);         // sets
        send_sample(1'b1, 0, 0, 19661, 1'b0, 0);         // 200 mg, quiet duty, holds
        send_sample(1'b1, 0, 0, 18384, 1'b0, 0);         // 122 mg clears

        // Random phases over a range of register settings, extremes right after the reset settings.
        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                case (phase)
                    1: begin thr = 0; gas = 0; quiet = 0; shake = 100; end
                    2: begin thr = 4095; gas = 4095; quiet = 100; shake = 0; end
                    3: begin thr = 1; gas = 2048; quiet = 12'hF7F; shake = 12'h065; end
                    6: begin thr = int'(RST_SHAKE_THR); gas = int'(RST_GAS_THR);
                             quiet = int'(RST_QUIET_DUTY); shake = int'(RST_SHAKE_DUTY); end
                    default:
                    begin
                        thr = $urandom_range(20, 1500);
                        gas = $urandom_range(0, 4095);
                        quiet = $urandom_range(0, 4095);
                        shake = $urandom_range(0, 4095);
                    end
                endcase
                load_settings(thr, gas, quiet, shake);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                steady = (i < 30);
                random_sample();
            end
        end

        drain();
        repeat (60) @(posedge clk);

        $display("Covered %0d sample items and %0d results over %0d register settings.",
                 samples_seen, reports_seen, settings_used);
        $display("Shaking was declared %0d times and cleared %0d times.",
                 detections, clearances);
        if (outstanding != 0)
            $display("%0t: %0d expected results never arrived", $time, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS shake_gas_flame_alarm_unit");
        else
            $display("FAIL shake_gas_flame_alarm_unit");
        $finish;
    end

endmodule
